[hdl/spl_pkg.sv]
package spl_pkg;

	localparam int MAX_POINTS_DEF = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int DIV_STEPS = 30;
	localparam logic [4:0] POINT_COUNT_RST = 5'd2;
	localparam logic [31:0] THREE_Q30 = 32'hC000_0000;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_EVAL = 1'b1
	} spl_op_t;

	typedef enum logic [1:0] {
		REGION_BELOW   = 2'd0,
		REGION_ABOVE   = 2'd1,
		REGION_SEGMENT = 2'd2,
		REGION_NONE    = 2'd3
	} spl_region_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_FIRST,
		F_LAST,
		F_SCAN,
		F_PUSH
	} spl_front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_PREP,
		B_DIV,
		B_MUL1,
		B_MUL2,
		B_MUL3,
		B_SUM,
		B_OUT
	} spl_back_state_t;

	typedef struct packed {
		spl_region_t        region;
		logic signed [31:0] x;
		logic signed [31:0] x0;
		logic signed [31:0] x1;
		logic signed [31:0] y0;
		logic signed [31:0] y1;
	} spl_job_t;

endpackage

[hdl/spl_if.sv]
interface spl_in_if;
	logic               valid;
	logic               ready;
	logic               operation;
	logic [3:0]         point_index;
	logic signed [31:0] position;
	logic signed [31:0] point_value;

	modport source(output valid, output operation, output point_index, output position,
		output point_value, input ready);
	modport sink(input valid, input operation, input point_index, input position,
		input point_value, output ready);
endinterface

interface spl_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic [1:0]         region;

	modport source(output valid, output value, output region, input ready);
	modport sink(input valid, input value, input region, output ready);
endinterface

[hdl/spl_ram.sv]
module spl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hdl/spl_front.sv]
module spl_front #(
	parameter int MAX_POINTS = spl_pkg::MAX_POINTS_DEF,
	localparam int AW = $clog2(MAX_POINTS)
) (
	input  logic               clk,
	input  logic               arst_n,
	spl_in_if.sink             in_ch,
	input  logic [4:0]         point_count,
	output logic               ram_we,
	output logic [AW-1:0]      ram_waddr,
	output logic [31:0]        ram_wx,
	output logic [31:0]        ram_wy,
	output logic [AW-1:0]      ram_raddr,
	input  logic signed [31:0] rd_x,
	input  logic signed [31:0] rd_y,
	output logic               job_valid,
	input  logic               job_ready,
	output spl_pkg::spl_job_t  job
);

	spl_pkg::spl_front_state_t state_q, state_d;
	logic [AW-1:0]      idx_q;
	logic [AW-1:0]      last_idx;
	logic signed [31:0] x_q;
	logic signed [31:0] px_q;
	logic signed [31:0] py_q;
	spl_pkg::spl_job_t  job_q;
	logic               hit;
	logic               accept;

	always_comb begin
		if (point_count < 5'd2) begin
			last_idx = AW'(1);
		end else if (32'(point_count) > MAX_POINTS) begin
			last_idx = AW'(MAX_POINTS - 1);
		end else begin
			last_idx = AW'(point_count - 5'd1);
		end
	end

	assign accept = in_ch.valid && in_ch.ready;
	assign hit = (x_q >= px_q) && (x_q <= rd_x);

	always_comb begin
		state_d = state_q;
		case (state_q)
			spl_pkg::F_IDLE: begin
				if (accept && in_ch.operation == spl_pkg::OP_EVAL) begin
					state_d = spl_pkg::F_FIRST;
				end
			end
			spl_pkg::F_FIRST: begin
				state_d = (x_q <= rd_x) ? spl_pkg::F_PUSH : spl_pkg::F_LAST;
			end
			spl_pkg::F_LAST: begin
				state_d = (x_q >= rd_x) ? spl_pkg::F_PUSH : spl_pkg::F_SCAN;
			end
			spl_pkg::F_SCAN: begin
				if (hit || idx_q == last_idx) begin
					state_d = spl_pkg::F_PUSH;
				end
			end
			spl_pkg::F_PUSH: begin
				if (job_ready) begin
					state_d = spl_pkg::F_IDLE;
				end
			end
			default: state_d = spl_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = 1'b0;
		job_valid   = 1'b0;
		ram_raddr   = '0;
		case (state_q)
			spl_pkg::F_IDLE:  in_ch.ready = 1'b1;
			spl_pkg::F_FIRST: ram_raddr = last_idx;
			spl_pkg::F_LAST:  ram_raddr = AW'(1);
			spl_pkg::F_SCAN:  ram_raddr = idx_q + AW'(1);
			spl_pkg::F_PUSH:  job_valid = 1'b1;
			default: ;
		endcase
	end

	assign ram_we    = accept && in_ch.operation == spl_pkg::OP_LOAD
		&& 32'(in_ch.point_index) < MAX_POINTS;
	assign ram_waddr = AW'(in_ch.point_index);
	assign ram_wx    = in_ch.position;
	assign ram_wy    = in_ch.point_value;
	assign job       = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spl_pkg::F_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == spl_pkg::F_LAST) begin
				idx_q <= AW'(1);
			end else if (state_q == spl_pkg::F_SCAN && !hit && idx_q != last_idx) begin
				idx_q <= idx_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			spl_pkg::F_IDLE: begin
				if (accept) begin
					x_q <= in_ch.position;
				end
			end
			spl_pkg::F_FIRST: begin
				px_q         <= rd_x;
				py_q         <= rd_y;
				job_q.region <= spl_pkg::REGION_BELOW;
				job_q.y0     <= rd_y;
			end
			spl_pkg::F_LAST: begin
				job_q.region <= spl_pkg::REGION_ABOVE;
				job_q.y0     <= rd_y;
			end
			spl_pkg::F_SCAN: begin
				if (hit) begin
					job_q <= '{region: spl_pkg::REGION_SEGMENT, x: x_q, x0: px_q, x1: rd_x,
						y0: py_q, y1: rd_y};
				end else if (idx_q == last_idx) begin
					job_q.region <= spl_pkg::REGION_NONE;
					job_q.y0     <= '0;
				end else begin
					px_q <= rd_x;
					py_q <= rd_y;
				end
			end
			default: ;
		endcase
	end

endmodule

[hdl/spl_queue.sv]
module spl_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  spl_pkg::spl_job_t push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output spl_pkg::spl_job_t pop_data
);

	localparam int D  = spl_pkg::QUEUE_DEPTH;
	localparam int PW = $clog2(D);
	localparam int CW = $clog2(D + 1);

	spl_pkg::spl_job_t mem_q [D];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = cnt_q != CW'(D);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rp_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PW'(D - 1)) ? '0 : wp_q + PW'(1);
			end
			if (do_pop) begin
				rp_q <= (rp_q == PW'(D - 1)) ? '0 : rp_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= push_data;
		end
	end

endmodule

[hdl/spl_back.sv]
module spl_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_ready,
	input  spl_pkg::spl_job_t job,
	spl_out_if.source         out_ch
);

	spl_pkg::spl_back_state_t state_q, state_d;
	spl_pkg::spl_job_t  job_q;
	logic [4:0]         cnt_q;
	logic [31:0]        w_q;
	logic [31:0]        r_q;
	logic [30:0]        q_q;
	logic [30:0]        t2_q;
	logic [31:0]        s_q;
	logic [30:0]        f_q;
	logic [31:0]        ady_q;
	logic               neg_q;
	logic [31:0]        mag_q;
	logic signed [31:0] value_q;

	logic signed [32:0] wd;
	logic signed [32:0] dxd;
	logic signed [32:0] dyd;
	logic [32:0]        r2;
	logic               ge;
	logic [61:0]        tt;
	logic [62:0]        fs;
	logic [62:0]        ma;

	assign wd  = {job_q.x1[31], job_q.x1} - {job_q.x0[31], job_q.x0};
	assign dxd = {job_q.x[31], job_q.x} - {job_q.x0[31], job_q.x0};
	assign dyd = {job_q.y1[31], job_q.y1} - {job_q.y0[31], job_q.y0};
	assign r2  = {r_q, 1'b0};
	assign ge  = r2 >= {1'b0, w_q};
	assign tt  = 62'(q_q) * 62'(q_q);
	assign fs  = 63'(t2_q) * 63'(s_q);
	assign ma  = 63'(f_q) * 63'(ady_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			spl_pkg::B_IDLE: begin
				if (job_valid) begin
					state_d = (job.region == spl_pkg::REGION_SEGMENT) ? spl_pkg::B_PREP
						: spl_pkg::B_OUT;
				end
			end
			spl_pkg::B_PREP: begin
				state_d = (wd[31:0] == '0) ? spl_pkg::B_MUL1 : spl_pkg::B_DIV;
			end
			spl_pkg::B_DIV: begin
				if (cnt_q == 5'(spl_pkg::DIV_STEPS - 1)) begin
					state_d = spl_pkg::B_MUL1;
				end
			end
			spl_pkg::B_MUL1: state_d = spl_pkg::B_MUL2;
			spl_pkg::B_MUL2: state_d = spl_pkg::B_MUL3;
			spl_pkg::B_MUL3: state_d = spl_pkg::B_SUM;
			spl_pkg::B_SUM:  state_d = spl_pkg::B_OUT;
			spl_pkg::B_OUT: begin
				if (out_ch.ready) begin
					state_d = spl_pkg::B_IDLE;
				end
			end
			default: state_d = spl_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		job_ready    = 1'b0;
		out_ch.valid = 1'b0;
		case (state_q)
			spl_pkg::B_IDLE: job_ready = 1'b1;
			spl_pkg::B_OUT:  out_ch.valid = 1'b1;
			default: ;
		endcase
	end

	assign out_ch.value  = value_q;
	assign out_ch.region = job_q.region;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spl_pkg::B_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == spl_pkg::B_DIV) begin
				cnt_q <= cnt_q + 5'd1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			spl_pkg::B_IDLE: begin
				if (job_valid) begin
					job_q   <= job;
					value_q <= job.y0;
				end
			end
			spl_pkg::B_PREP: begin
				w_q   <= wd[31:0];
				neg_q <= dyd[32];
				ady_q <= dyd[32] ? 32'(-dyd) : dyd[31:0];
				if (wd[31:0] != '0 && dxd[31:0] >= wd[31:0]) begin
					r_q <= dxd[31:0] - wd[31:0];
					q_q <= 31'd1;
				end else begin
					r_q <= dxd[31:0];
					q_q <= '0;
				end
			end
			spl_pkg::B_DIV: begin
				r_q <= ge ? 32'(r2 - {1'b0, w_q}) : r2[31:0];
				q_q <= {q_q[29:0], ge};
			end
			spl_pkg::B_MUL1: begin
				t2_q <= tt[60:30];
				s_q  <= spl_pkg::THREE_Q30 - {q_q, 1'b0};
			end
			spl_pkg::B_MUL2: f_q <= fs[60:30];
			spl_pkg::B_MUL3: mag_q <= ma[61:30];
			spl_pkg::B_SUM: begin
				value_q <= neg_q ? job_q.y0 - $signed(mag_q) : job_q.y0 + $signed(mag_q);
			end
			default: ;
		endcase
	end

endmodule

[hdl/smoothstep_spline_interpolator.sv]
// Load beat: written to the point tables in the cycle it is taken; the front end stays ready.
// Evaluate beat: the front end searches the table, one entry per cycle, then hands a job to a
// two-entry queue; the back end passes a boundary result straight to its output and computes
// an interpolated one with its 30-step divider, which it skips for a segment of zero width.
// Reset clears control state and sets point_count to 2; point tables are undefined until loaded.
module smoothstep_spline_interpolator #(
	parameter int MAX_POINTS = spl_pkg::MAX_POINTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [4:0] cfg_wdata,
	spl_in_if.sink     in_ch,
	spl_out_if.source  out_ch
);

	localparam int AW = $clog2(MAX_POINTS);

	logic [4:0]        point_count_q;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [AW-1:0]     ram_raddr;
	logic [31:0]       ram_wx;
	logic [31:0]       ram_wy;
	logic [31:0]       rd_x;
	logic [31:0]       rd_y;
	logic              push_valid;
	logic              push_ready;
	spl_pkg::spl_job_t push_data;
	logic              pop_valid;
	logic              pop_ready;
	spl_pkg::spl_job_t pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= spl_pkg::POINT_COUNT_RST;
		end else if (cfg_we) begin
			point_count_q <= cfg_wdata;
		end
	end

	spl_front #(.MAX_POINTS(MAX_POINTS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.point_count (point_count_q),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wx      (ram_wx),
		.ram_wy      (ram_wy),
		.ram_raddr   (ram_raddr),
		.rd_x        (rd_x),
		.rd_y        (rd_y),
		.job_valid   (push_valid),
		.job_ready   (push_ready),
		.job         (push_data)
	);

	spl_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_x (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wx),
		.raddr (ram_raddr),
		.rdata (rd_x)
	);

	spl_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_y (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wy),
		.raddr (ram_raddr),
		.rdata (rd_y)
	);

	spl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	spl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (pop_valid),
		.job_ready (pop_ready),
		.job       (pop_data),
		.out_ch    (out_ch)
	);

endmodule

[tb/smoothstep_spline_interpolator_tb.sv]
`timescale 1ns / 100ps

localparam logic [63:0] UNIT_Q30 = 64'd1 << 30;

typedef struct {
	spl_pkg::spl_op_t   op;
	logic [3:0]         slot;
	logic signed [31:0] x;
	logic signed [31:0] y;
} spline_beat_t;

typedef struct {
	logic signed [31:0]   value;
	spl_pkg::spl_region_t region;
} spline_result_t;

class spline_shadow;
	logic signed [31:0] knot_x[spl_pkg::MAX_POINTS_DEF];
	logic signed [31:0] knot_y[spl_pkg::MAX_POINTS_DEF];
	logic [4:0]         point_count;
	spline_result_t     pending_values[$];
	int                 errors;

	function new();
		foreach (knot_x[i]) begin
			knot_x[i] = '0;
			knot_y[i] = '0;
		end
		point_count = spl_pkg::POINT_COUNT_RST;
		errors = 0;
	endfunction

	function void set_point_count(logic [4:0] count);
		point_count = count;
	endfunction

	function int used_points();
		int n;
		n = int'(point_count);
		if (n < 2) n = 2;
		if (n > spl_pkg::MAX_POINTS_DEF) n = spl_pkg::MAX_POINTS_DEF;
		return n;
	endfunction

	function logic signed [31:0] smooth_blend(longint x, longint x0, longint x1, longint y0,
		longint y1);
		logic [63:0] w, dx, t, t2, s, f, mag, ady;
		longint      dy, sum;
		w = x1 - x0;
		dx = x - x0;
		dy = y1 - y0;
		ady = (dy < 0) ? -dy : dy;
		t = '0;
		if (w != 0) t = (dx << 30) / w;
		if (t > UNIT_Q30) t = UNIT_Q30;
		t2 = (t * t) >> 30;
		s = 3 * UNIT_Q30 - 2 * t;
		f = (t2 * s) >> 30;
		mag = (f * ady) >> 30;
		sum = (dy < 0) ? y0 - longint'(mag) : y0 + longint'(mag);
		return sum[31:0];
	endfunction

	function spline_result_t interpolate(logic signed [31:0] pos);
		spline_result_t res;
		int             n;
		bit             found;
		n = used_points();
		found = 0;
		res.value = '0;
		res.region = spl_pkg::REGION_NONE;
		if (pos <= knot_x[0]) begin
			res.value = knot_y[0];
			res.region = spl_pkg::REGION_BELOW;
		end else if (pos >= knot_x[n - 1]) begin
			res.value = knot_y[n - 1];
			res.region = spl_pkg::REGION_ABOVE;
		end else begin
			for (int i = 0; i + 1 < n; i++) begin
				if (!found && pos >= knot_x[i] && pos <= knot_x[i + 1]) begin
					res.value = smooth_blend(longint'(pos), longint'(knot_x[i]),
						longint'(knot_x[i + 1]), longint'(knot_y[i]),
						longint'(knot_y[i + 1]));
					res.region = spl_pkg::REGION_SEGMENT;
					found = 1;
				end
			end
		end
		return res;
	endfunction

	function void note_beat(spline_beat_t beat);
		if (beat.op == spl_pkg::OP_LOAD) begin
			if (beat.slot < spl_pkg::MAX_POINTS_DEF) begin
				knot_x[beat.slot] = beat.x;
				knot_y[beat.slot] = beat.y;
			end
		end else begin
			pending_values.push_back(interpolate(beat.x));
		end
	endfunction

	function void check_result(logic signed [31:0] value, logic [1:0] region);
		spline_result_t want;
		if (pending_values.size() == 0) begin
			$error("value: none expected, actual %0d (region %0d)", value, region);
			errors++;
			return;
		end
		want = pending_values.pop_front();
		if (value !== want.value) begin
			$error("value: expected %0d, actual %0d", want.value, value);
			errors++;
		end
		if (region !== want.region) begin
			$error("region: expected %0d, actual %0d", want.region, region);
			errors++;
		end
	endfunction
endclass

module smoothstep_spline_interpolator_tb;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE_CYCLES = 64;
	localparam int ITEM_TARGET = 1950;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [4:0]   cfg_wdata;
	int           send_idle = 0;
	int           recv_stall = 0;
	int           beats_sent = 0;
	int           cycles = 0;
	spline_shadow shadow = new();

	spl_in_if  in_ch();
	spl_out_if out_ch();

	smoothstep_spline_interpolator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			shadow.check_result(out_ch.value, out_ch.region);
		out_ch.ready <= ($urandom_range(99) >= recv_stall);
	end

	function automatic spline_beat_t make_beat(spl_pkg::spl_op_t op, int slot,
		logic signed [31:0] x, logic signed [31:0] y);
		spline_beat_t beat;
		beat.op = op;
		beat.slot = 4'(slot);
		beat.x = x;
		beat.y = y;
		return beat;
	endfunction

	function automatic logic signed [31:0] pick_x(int spread);
		logic signed [31:0] r;
		case (spread)
			0: r = $urandom;
			1: r = $urandom_range(32'h000F_FFFF) - 32'h0008_0000;
			default: r = ($urandom_range(7) << 14) - 32'h0001_0000;
		endcase
		return r;
	endfunction

	task automatic send_beat(spline_beat_t beat);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.operation <= beat.op;
		in_ch.point_index <= beat.slot;
		in_ch.position <= beat.x;
		in_ch.point_value <= beat.y;
		do @(posedge clk); while (!in_ch.ready);
		shadow.note_beat(beat);
		beats_sent++;
	endtask

	task automatic settle();
		in_ch.valid <= 1'b0;
		while (shadow.pending_values.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_point_count(logic [4:0] count);
		cfg_we <= 1'b1;
		cfg_wdata <= count;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow.set_point_count(count);
	endtask

	task automatic load_table(int n);
		int  xs[$];
		int  spread;
		bit  ordered;
		spread = $urandom_range(2);
		ordered = ($urandom_range(9) < 8);
		repeat (n) xs.push_back(pick_x(spread));
		if (ordered) xs.sort();
		for (int i = 0; i < n; i++)
			send_beat(make_beat(spl_pkg::OP_LOAD, i, xs[i],
				($urandom_range(2) == 0) ? $urandom : pick_x(1)));
	endtask

	task automatic query(int n);
		longint      lo, hi, pos;
		logic [63:0] r64;
		int          roll;
		lo = longint'(shadow.knot_x[0]);
		hi = lo;
		for (int i = 1; i < n; i++) begin
			if (shadow.knot_x[i] < lo) lo = longint'(shadow.knot_x[i]);
			if (shadow.knot_x[i] > hi) hi = longint'(shadow.knot_x[i]);
		end
		roll = $urandom_range(99);
		r64 = {$urandom, $urandom};
		if (roll < 70)
			pos = lo + longint'(r64 % (hi - lo + 1));
		else if (roll < 85)
			pos = longint'(shadow.knot_x[$urandom_range(n - 1)])
				+ longint'($urandom_range(2)) - 1;
		else
			pos = longint'(r64[31:0]);
		send_beat(make_beat(spl_pkg::OP_EVAL, $urandom, pos[31:0], $urandom));
	endtask

	initial begin
		int         counts[$];
		int         phase;
		int         n;
		logic [4:0] count;
		counts = '{0, 1, 2, 16, 17, 31};
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.operation <= spl_pkg::OP_LOAD;
		in_ch.point_index <= '0;
		in_ch.position <= '0;
		in_ch.point_value <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// widest segment, extreme values
		send_beat(make_beat(spl_pkg::OP_LOAD, 0, 32'h8000_0000, 32'h7FFF_FFFF));
		send_beat(make_beat(spl_pkg::OP_LOAD, 1, 32'h7FFF_FFFF, 32'h8000_0000));
		send_beat(make_beat(spl_pkg::OP_EVAL, 0, 32'h8000_0000, 0));
		send_beat(make_beat(spl_pkg::OP_EVAL, 15, 32'h8000_0001, 32'hFFFF_FFFF));
		send_beat(make_beat(spl_pkg::OP_EVAL, 0, 32'h0000_0000, 0));
		send_beat(make_beat(spl_pkg::OP_EVAL, 0, 32'h0000_0001, 0));
		send_beat(make_beat(spl_pkg::OP_EVAL, 0, 32'h7FFF_FFFE, 0));
		send_beat(make_beat(spl_pkg::OP_EVAL, 0, 32'h7FFF_FFFF, 0));
		send_beat(make_beat(spl_pkg::OP_EVAL, 0, 32'hFFFF_FFFF, 0));
		// zero-width segment
		send_beat(make_beat(spl_pkg::OP_LOAD, 0, 32'h0001_0000, 32'h0002_0000));
		send_beat(make_beat(spl_pkg::OP_LOAD, 1, 32'h0001_0000, 32'hFFFF_FFFB));
		send_beat(make_beat(spl_pkg::OP_EVAL, 0, 32'h0001_0000, 0));
		send_beat(make_beat(spl_pkg::OP_EVAL, 0, 32'h0000_FFFF, 0));
		send_beat(make_beat(spl_pkg::OP_EVAL, 0, 32'h0001_0001, 0));
		send_beat(make_beat(spl_pkg::OP_LOAD, 15, 32'hDEAD_BEEF, 32'h1234_5678));
		// unsorted pair
		send_beat(make_beat(spl_pkg::OP_LOAD, 0, 32'h0000_0064, 32'h0000_0000));
		send_beat(make_beat(spl_pkg::OP_LOAD, 1, 32'hFFFF_FF9C, 32'h7FFF_FFFF));
		send_beat(make_beat(spl_pkg::OP_EVAL, 0, 32'h0000_0000, 0));
		send_beat(make_beat(spl_pkg::OP_EVAL, 0, 32'h0000_00C8, 0));
		send_beat(make_beat(spl_pkg::OP_EVAL, 0, 32'hFFFF_FF00, 0));
		// midpoint and one-sixth point
		send_beat(make_beat(spl_pkg::OP_LOAD, 0, 32'h0000_0000, 32'h0000_0000));
		send_beat(make_beat(spl_pkg::OP_LOAD, 1, 32'h0003_0000, 32'h0001_0000));
		send_beat(make_beat(spl_pkg::OP_EVAL, 0, 32'h0001_8000, 0));
		send_beat(make_beat(spl_pkg::OP_EVAL, 0, 32'h0000_8000, 0));

		phase = 0;
		while (beats_sent < ITEM_TARGET) begin
			settle();
			case (phase % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 45; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 45; end
				default: begin send_idle = 24; recv_stall = 24; end
			endcase
			count = 5'((phase < counts.size()) ? counts[phase] : $urandom_range(31));
			write_point_count(count);
			n = shadow.used_points();
			repeat (3) begin
				load_table(n);
				repeat ($urandom_range(8, 24)) begin
					if ($urandom_range(9) == 0)
						send_beat(make_beat(spl_pkg::OP_LOAD, $urandom, $urandom, $urandom));
					else
						query(n);
				end
			end
			phase++;
		end

		settle();
		if (shadow.errors == 0 && shadow.pending_values.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
